// ===== hdl/tspbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tspbf_pkg
// Shared types and constants for the brute-force tour search unit.
// ----------------------------------------------------------------------------
package tspbf_pkg;

	localparam int MaxNodes  = 8;
	localparam int NodeW     = 3;
	localparam int DistW     = 16;
	localparam int CostW     = 20;
	localparam int LvlW      = 4;
	localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};
	localparam logic [3:0]       NodeCountReset = 4'd4;

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdStart = 1'b1;

	typedef struct packed {
		logic             command;
		logic [2:0]       row;
		logic [2:0]       col;
		logic [DistW-1:0] distance;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]       position;
		logic [2:0]       city;
		logic [CostW-1:0] tour_cost;
		logic             last;
	} out_beat_t;

	typedef struct packed {
		logic init;      // reset order, best cost
		logic swap;      // swap order[depth] and order[idx]
		logic sum_clr;   // start new tour sum
		logic sum_add;   // add edge(order[k], order[k+1 mod n])
		logic commit;    // compare sum with best
	} dp_cmd_t;

endpackage

// ===== hdl/tspbf_datapath.sv =====
// ----------------------------------------------------------------------------
// tspbf_datapath
// Distance memory, tour order, edge accumulator and best tour store.
// ----------------------------------------------------------------------------
module tspbf_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  tspbf_pkg::in_beat_t     wr_beat,
	input  tspbf_pkg::dp_cmd_t      cmd,
	input  logic [2:0]              depth,
	input  logic [2:0]              idx,
	input  logic [2:0]              edge_k,
	input  logic [3:0]              n,
	input  logic [2:0]              rd_pos,
	output logic [2:0]              best_city,
	output logic [19:0]             best_cost
);
	import tspbf_pkg::*;

	logic [DistW-1:0] mem_q [64];
	logic [DistW-1:0] rd_data_q;
	logic [NodeW-1:0] order_q [MaxNodes];
	logic [NodeW-1:0] best_q  [MaxNodes];
	logic [CostW-1:0] best_cost_q;
	logic [CostW:0]   sum_q;
	logic [CostW:0]   acc;
	logic [NodeW-1:0] from_c, to_c;
	logic [2:0]       k_next;
	logic             add_d_q;

	assign k_next = (edge_k + 3'd1 == n[2:0] || {1'b0, edge_k} + 4'd1 == n) ? 3'd0
		: edge_k + 3'd1;
	assign from_c = order_q[edge_k];
	assign to_c   = order_q[k_next];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[{wr_beat.row, wr_beat.col}] <= wr_beat.distance;
		rd_data_q <= mem_q[{from_c, to_c}];
	end

	assign acc = sum_q + {{(CostW+1-DistW){1'b0}}, rd_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxNodes; i++) begin
				order_q[i] <= NodeW'(i);
				best_q[i]  <= '0;
			end
			best_cost_q <= CostMax;
			sum_q       <= '0;
			add_d_q     <= 1'b0;
		end else begin
			add_d_q <= cmd.sum_add;
			if (cmd.init) begin
				for (int i = 0; i < MaxNodes; i++) order_q[i] <= NodeW'(i);
				best_cost_q <= CostMax;
			end
			if (cmd.swap) begin
				order_q[depth] <= order_q[idx];
				order_q[idx]   <= order_q[depth];
			end
			if (cmd.sum_clr) sum_q <= '0;
			else if (add_d_q) sum_q <= (acc > {1'b0, CostMax}) ? {1'b0, CostMax} : acc;
			if (cmd.commit && sum_q[CostW-1:0] < best_cost_q) begin
				best_cost_q <= sum_q[CostW-1:0];
				best_q      <= order_q;
			end
		end
	end

	assign best_city = best_q[rd_pos];
	assign best_cost = best_cost_q;

endmodule

// ===== hdl/tspbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tspbf_ctrl
// Sequencer: iterative swap recursion with a level counter stack.
// ----------------------------------------------------------------------------
module tspbf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tspbf_pkg::in_beat_t   in_beat,
	output logic                  in_stall,
	input  logic [3:0]            node_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  wr_en,
	output tspbf_pkg::dp_cmd_t    cmd,
	output logic [2:0]            depth,
	output logic [2:0]            idx,
	output logic [2:0]            edge_k,
	output logic [3:0]            n,
	output logic [2:0]            rd_pos,
	output logic                  last
);
	import tspbf_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ENTER = 7'b0000010,
		S_SUM   = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_UNDO  = 7'b0010000,
		S_NEXT  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [3:0]       n_q;
	logic [3:0]       depth_q;
	logic [LvlW-1:0]  lvl_q [MaxNodes];
	logic [2:0]       k_q;
	logic [1:0]       drain_q;
	logic [2:0]       pos_q;
	logic             accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign wr_en    = accept && in_beat.command == CmdWrite;
	assign depth    = depth_q[2:0];
	assign idx      = lvl_q[depth_q[2:0]][2:0];
	assign edge_k   = k_q;
	assign n        = n_q;
	assign rd_pos   = pos_q;
	assign out_valid = (state_q == S_EMIT);
	assign last     = ({1'b0, pos_q} + 4'd1 == n_q);

	always_comb begin
		cmd = '0;
		cmd.init    = accept && in_beat.command == CmdStart;
		cmd.swap    = (state_q == S_ENTER || state_q == S_UNDO) && depth_q < n_q &&
			lvl_q[depth_q[2:0]][2:0] != depth_q[2:0];
		cmd.sum_clr = (state_q == S_ENTER) && depth_q >= n_q;
		cmd.sum_add = (state_q == S_SUM);
		cmd.commit  = (state_q == S_DRAIN) && drain_q == 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= NodeCountReset;
			depth_q <= '0;
			k_q     <= '0;
			drain_q <= '0;
			pos_q   <= '0;
			for (int i = 0; i < MaxNodes; i++) lvl_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_beat.command == CmdStart) begin
						n_q <= (node_count == 4'd0) ? 4'd1 :
							(node_count > 4'(MaxNodes)) ? 4'(MaxNodes) : node_count;
						depth_q  <= 4'd1;
						lvl_q[1] <= 4'd1;
						state_q  <= S_ENTER;
					end
				end
				S_ENTER: begin
					if (depth_q >= n_q) begin
						k_q     <= '0;
						state_q <= S_SUM;
					end else if (depth_q + 4'd1 < 4'(MaxNodes) + 4'd1) begin
						depth_q <= depth_q + 4'd1;
						if (depth_q + 4'd1 < 4'(MaxNodes))
							lvl_q[depth_q[2:0] + 3'd1] <= depth_q + 4'd1;
					end
				end
				S_SUM: begin
					if ({1'b0, k_q} + 4'd1 >= n_q) begin
						drain_q <= 2'd1;
						state_q <= S_DRAIN;
					end else k_q <= k_q + 3'd1;
				end
				S_DRAIN: begin
					if (drain_q == 2'd0) begin
						// single city: one tour, nothing to unwind
						if (depth_q == 4'd1) begin
							pos_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							depth_q <= depth_q - 4'd1;
							state_q <= S_UNDO;
						end
					end else drain_q <= drain_q - 2'd1;
				end
				S_UNDO: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (lvl_q[depth_q[2:0]] + 4'd1 < n_q) begin
						lvl_q[depth_q[2:0]] <= lvl_q[depth_q[2:0]] + 4'd1;
						state_q <= S_ENTER;
					end else if (depth_q == 4'd1) begin
						pos_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						depth_q <= depth_q - 4'd1;
						state_q <= S_UNDO;
					end
				end
				S_EMIT: begin
					if (!out_stall) begin
						if (last) state_q <= S_IDLE;
						else pos_q <= pos_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/tsp_brute_force_search_unit.sv =====
// ----------------------------------------------------------------------------
// tsp_brute_force_search_unit
// Exhaustive shortest closed tour search over an asymmetric distance matrix.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  in_beat_t
// out      out  out_valid/out_stall out_beat_t
// cfg      in   cfg_we             cfg_data (node_count)
// A start walks (n-1)! tours, each an edge sum loop plus the recursion
// steps, then emits n beats. Reset clears control; the distance memory is
// undefined until written. Input is stalled for the whole search and
// emission.
// ----------------------------------------------------------------------------
module tsp_brute_force_search_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tspbf_pkg::in_beat_t   in_beat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tspbf_pkg::out_beat_t  out_beat,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_data
);
	import tspbf_pkg::*;

	logic [3:0]  node_count_q;
	logic        wr_en, last;
	dp_cmd_t     cmd;
	logic [2:0]  depth, idx, edge_k, rd_pos, best_city;
	logic [3:0]  n;
	logic [19:0] best_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= NodeCountReset;
		else if (cfg_we) node_count_q <= cfg_data;
	end

	tspbf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_beat, .in_stall,
		.node_count(node_count_q), .out_valid, .out_stall,
		.wr_en, .cmd, .depth, .idx, .edge_k, .n, .rd_pos, .last
	);

	tspbf_datapath u_dp (
		.clk, .arst_n, .wr_en, .wr_beat(in_beat), .cmd, .depth, .idx,
		.edge_k, .n, .rd_pos, .best_city, .best_cost
	);

	assign out_beat.position  = rd_pos;
	assign out_beat.city      = best_city;
	assign out_beat.tour_cost = best_cost;
	assign out_beat.last      = last;

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during emission");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("stalled beat changed");
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !out_valid) else $error("write during search");

endmodule
